/* rtl/core/psw_pkg.sv */
`timescale 1ns / 1ps

package psw_pkg;

    localparam int MAX_PROCS_DEF = 32;

    localparam int ID_W    = 8;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int TIME_W  = 21;
    localparam int AVG_W   = 29;
    localparam int FRAC_W  = 8;

    // sized for the largest capacity of 64 jobs
    localparam int RUN_W = 22;
    localparam int SUM_W = 28;
    localparam int DVD_W = SUM_W + FRAC_W;

    localparam int S_TDATA_W  = 32;
    localparam int M_FIELDS_W = ID_W + BURST_W + PRIO_W + 2 * TIME_W + 2 * AVG_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } job_t;

    localparam int JOB_W = $bits(job_t);

endpackage

/* rtl/core/psw_ram.sv */
`timescale 1ns / 1ps

module psw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/psw_div.sv */
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module psw_div #(
    parameter int DVD_W = 36,
    parameter int DVS_W = 6,
    localparam int CW = $clog2(DVD_W + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [DVD_W-1:0] quotient
);

    logic             busy_reg, busy_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(DVD_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = diff[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/core/priority_schedule_wait_times.sv */
`timescale 1ns / 1ps

// Non-preemptive priority scheduler. Jobs stream in one per transaction;
// the transaction with s_tlast ends the set and the block then sorts the
// held jobs by ascending priority in place in one simple dual-port RAM
// (one read and one write a cycle) with an exchange sort. A pass over the
// sorted jobs sums the waiting and turnaround times, then two shared-nothing
// bit-serial dividers form both averages. Results leave in scheduled order,
// the last with m_tlast; a result is loaded only once the one before it has
// been taken. Jobs arriving while MAX_PROCS are held are discarded and
// m_tuser is set on every result of that set. Input is not accepted between
// the end of a set and the loading of its final result; that final result
// may still wait on m_tready while the next set loads.
module priority_schedule_wait_times #(
    parameter int MAX_PROCS = psw_pkg::MAX_PROCS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // job_id[7:0], burst_time[23:8], prio_level[31:24]
    input  logic [psw_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // job_id_out[7:0], burst_out[23:8], prio_out[31:24], wait_time[52:32],
    // turnaround_time[73:53], avg_wait_fx[102:74], avg_turn_fx[131:103], zero pad
    output logic [psw_pkg::M_TDATA_W-1:0]  m_tdata,
    // dropped_flag
    output logic                           m_tuser,
    output logic                           m_tlast
);

    import psw_pkg::*;

    localparam int AW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam int PAD_W = M_TDATA_W - M_FIELDS_W;

    typedef enum logic [9:0] {
        S_LOAD = 10'b0000000001,
        S_LDI  = 10'b0000000010,
        S_GETI = 10'b0000000100,
        S_CMP  = 10'b0000001000,
        S_WRI  = 10'b0000010000,
        S_SUM  = 10'b0000100000,
        S_DST  = 10'b0001000000,
        S_DIV  = 10'b0010000000,
        S_ORD  = 10'b0100000000,
        S_OLD  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             vld_reg, vld_next;
    logic             m_tvalid_reg, m_tvalid_next;

    job_t             cur_reg, cur_next;
    logic [RUN_W-1:0] run_reg, run_next;
    logic [SUM_W-1:0] sw_reg, sw_next;
    logic [SUM_W-1:0] st_reg, st_next;

    logic [ID_W-1:0]    oid_reg, oid_next;
    logic [BURST_W-1:0] oburst_reg, oburst_next;
    logic [PRIO_W-1:0]  oprio_reg, oprio_next;
    logic [TIME_W-1:0]  owait_reg, owait_next;
    logic [TIME_W-1:0]  oturn_reg, oturn_next;
    logic [AVG_W-1:0]   oavgw_reg, oavgw_next;
    logic [AVG_W-1:0]   oavgt_reg, oavgt_next;
    logic               odrop_reg, odrop_next;
    logic               olast_reg, olast_next;

    logic             we;
    logic [AW-1:0]    waddr;
    job_t             wdata;
    logic [AW-1:0]    raddr;
    logic [JOB_W-1:0] ram_rdata;
    job_t             rd;

    logic             div_start;
    logic             div_w_busy, div_t_busy;
    logic [DVD_W-1:0] quo_w, quo_t;

    logic             full;
    logic [CNT_W-1:0] count_inc, i_inc, j_inc, k_inc;
    logic [RUN_W-1:0] run_add;
    job_t             in_job;

    assign rd        = ram_rdata;
    assign full      = (count_reg == CNT_W'(MAX_PROCS));
    assign count_inc = count_reg + 1'b1;
    assign i_inc     = i_reg + 1'b1;
    assign j_inc     = j_reg + 1'b1;
    assign k_inc     = k_reg + 1'b1;
    assign run_add   = run_reg + RUN_W'(rd.burst);

    assign in_job.id    = s_tdata[ID_W-1:0];
    assign in_job.burst = s_tdata[ID_W+BURST_W-1:ID_W];
    assign in_job.prio  = s_tdata[ID_W+BURST_W+PRIO_W-1:ID_W+BURST_W];

    psw_ram #(
        .WIDTH(JOB_W),
        .DEPTH(MAX_PROCS)
    ) u_job_ram (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(ram_rdata)
    );

    psw_div #(
        .DVD_W(DVD_W),
        .DVS_W(CNT_W)
    ) u_div_wait (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend({sw_reg, FRAC_W'(0)}),
        .divisor (n_reg),
        .busy    (div_w_busy),
        .quotient(quo_w)
    );

    psw_div #(
        .DVD_W(DVD_W),
        .DVS_W(CNT_W)
    ) u_div_turn (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend({st_reg, FRAC_W'(0)}),
        .divisor (n_reg),
        .busy    (div_t_busy),
        .quotient(quo_t)
    );

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        n_next        = n_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        vld_next      = 1'b0;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        cur_next      = cur_reg;
        run_next      = run_reg;
        sw_next       = sw_reg;
        st_next       = st_reg;
        oid_next      = oid_reg;
        oburst_next   = oburst_reg;
        oprio_next    = oprio_reg;
        owait_next    = owait_reg;
        oturn_next    = oturn_reg;
        oavgw_next    = oavgw_reg;
        oavgt_next    = oavgt_reg;
        odrop_next    = odrop_reg;
        olast_next    = olast_reg;
        we            = 1'b0;
        waddr         = '0;
        wdata         = cur_reg;
        raddr         = '0;
        div_start     = 1'b0;

        case (state_reg)
            S_LOAD: begin
                if (s_tvalid) begin
                    if (!full) begin
                        we         = 1'b1;
                        waddr      = count_reg[AW-1:0];
                        wdata      = in_job;
                        count_next = count_inc;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        n_next     = full ? count_reg : count_inc;
                        i_next     = '0;
                        state_next = S_LDI;
                    end
                end
            end
            S_LDI: begin
                raddr      = i_reg[AW-1:0];
                state_next = S_GETI;
            end
            S_GETI: begin
                // entry i lives in cur_reg for the whole inner pass
                cur_next = rd;
                j_next   = i_inc;
                raddr    = i_inc[AW-1:0];
                if (i_inc >= n_reg) begin
                    k_next     = '0;
                    run_next   = '0;
                    sw_next    = '0;
                    st_next    = '0;
                    state_next = S_SUM;
                end else begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (cur_reg.prio > rd.prio) begin
                    we       = 1'b1;
                    waddr    = j_reg[AW-1:0];
                    wdata    = cur_reg;
                    cur_next = rd;
                end
                raddr  = j_inc[AW-1:0];
                j_next = j_inc;
                if (j_inc >= n_reg) begin
                    state_next = S_WRI;
                end
            end
            S_WRI: begin
                we         = 1'b1;
                waddr      = i_reg[AW-1:0];
                wdata      = cur_reg;
                i_next     = i_inc;
                raddr      = i_inc[AW-1:0];
                state_next = S_GETI;
            end
            S_SUM: begin
                raddr = k_reg[AW-1:0];
                if (k_reg < n_reg) begin
                    vld_next = 1'b1;
                    k_next   = k_inc;
                end
                if (vld_reg) begin
                    sw_next  = sw_reg + SUM_W'(run_reg);
                    run_next = run_add;
                    st_next  = st_reg + SUM_W'(run_add);
                end
                if (k_reg == n_reg) begin
                    state_next = S_DST;
                end
            end
            S_DST: begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (!div_w_busy && !div_t_busy) begin
                    k_next     = '0;
                    run_next   = '0;
                    state_next = S_ORD;
                end
            end
            S_ORD: begin
                if (!m_tvalid_reg || m_tready) begin
                    raddr      = k_reg[AW-1:0];
                    state_next = S_OLD;
                end
            end
            S_OLD: begin
                m_tvalid_next = 1'b1;
                oid_next      = rd.id;
                oburst_next   = rd.burst;
                oprio_next    = rd.prio;
                owait_next    = run_reg[TIME_W-1:0];
                oturn_next    = run_add[TIME_W-1:0];
                oavgw_next    = quo_w[AVG_W-1:0];
                oavgt_next    = quo_t[AVG_W-1:0];
                odrop_next    = ovf_reg;
                olast_next    = (k_inc == n_reg);
                run_next      = run_add;
                if (k_inc == n_reg) begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = S_LOAD;
                end else begin
                    k_next     = k_inc;
                    state_next = S_ORD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            vld_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            vld_reg      <= vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg      <= n_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        cur_reg    <= cur_next;
        run_reg    <= run_next;
        sw_reg     <= sw_next;
        st_reg     <= st_next;
        oid_reg    <= oid_next;
        oburst_reg <= oburst_next;
        oprio_reg  <= oprio_next;
        owait_reg  <= owait_next;
        oturn_reg  <= oturn_next;
        oavgw_reg  <= oavgw_next;
        oavgt_reg  <= oavgt_next;
        odrop_reg  <= odrop_next;
        olast_reg  <= olast_next;
    end

    assign s_tready = (state_reg == S_LOAD);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {PAD_W'(0), oavgt_reg, oavgw_reg, oturn_reg, owait_reg,
                       oprio_reg, oburst_reg, oid_reg};
    assign m_tuser  = odrop_reg;
    assign m_tlast  = olast_reg;

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import psw_pkg::*;

    localparam int CAP = MAX_PROCS_DEF;

    // one scheduled job as it should leave the block
    typedef struct {
        bit [ID_W-1:0]    job_id;
        bit [BURST_W-1:0] burst;
        bit [PRIO_W-1:0]  prio;
        bit [TIME_W-1:0]  wait_tm;
        bit [TIME_W-1:0]  turn_tm;
        bit [AVG_W-1:0]   avg_wait;
        bit [AVG_W-1:0]   avg_turn;
        bit               dropped;
        bit               is_last;
    } sched_result_t;

    class sched_scoreboard;
        job_t          held[$];
        bit            overflow;
        sched_result_t due[$];
        int            errors;
        int            results_seen;
        int            sets_done;
        int            overflow_sets;

        function int pending();
            return due.size();
        endfunction

        // accepted job: store it, and on the set's last job build the schedule
        function void note_job(job_t j, bit last);
            job_t          tmp;
            int            n;
            bit [63:0]     run;
            bit [63:0]     sum_wait;
            bit [63:0]     sum_turn;
            bit [63:0]     avg_w;
            bit [63:0]     avg_t;
            sched_result_t r;

            if (held.size() < CAP) held.push_back(j);
            else overflow = 1'b1;
            if (!last) return;

            n = held.size();
            // exchange sort, ties resolved exactly as the swap order gives
            for (int i = 0; i < n; i++) begin
                for (int k = i + 1; k < n; k++) begin
                    if (held[i].prio > held[k].prio) begin
                        tmp     = held[i];
                        held[i] = held[k];
                        held[k] = tmp;
                    end
                end
            end

            run      = 0;
            sum_wait = 0;
            sum_turn = 0;
            foreach (held[k]) begin
                sum_wait += run;
                run      += held[k].burst;
                sum_turn += run;
            end
            avg_w = (sum_wait * 256) / n;
            avg_t = (sum_turn * 256) / n;

            run = 0;
            foreach (held[k]) begin
                r.job_id   = held[k].id;
                r.burst    = held[k].burst;
                r.prio     = held[k].prio;
                r.wait_tm  = run[TIME_W-1:0];
                run       += held[k].burst;
                r.turn_tm  = run[TIME_W-1:0];
                r.avg_wait = avg_w[AVG_W-1:0];
                r.avg_turn = avg_t[AVG_W-1:0];
                r.dropped  = overflow;
                r.is_last  = (k == n - 1);
                due.push_back(r);
            end

            sets_done++;
            if (overflow) overflow_sets++;
            held.delete();
            overflow = 1'b0;
        endfunction

        function void cmp(string what, logic [63:0] exp_v, logic [63:0] got_v);
            if (exp_v !== got_v) begin
                errors++;
                if (errors <= 60)
                    $display("%0t: %s mismatch: expected %0d, actual %0d",
                             $time, what, exp_v, got_v);
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata, logic tuser, logic tlast);
            sched_result_t e;

            results_seen++;
            if (due.size() == 0) begin
                errors++;
                if (errors <= 60)
                    $display("%0t: unexpected result transaction: expected none, actual %h",
                             $time, tdata);
                return;
            end
            e = due.pop_front();
            cmp("job_id_out",      e.job_id,   tdata[7:0]);
            cmp("burst_out",       e.burst,    tdata[23:8]);
            cmp("prio_out",        e.prio,     tdata[31:24]);
            cmp("wait_time",       e.wait_tm,  tdata[52:32]);
            cmp("turnaround_time", e.turn_tm,  tdata[73:53]);
            cmp("avg_wait_fx",     e.avg_wait, tdata[102:74]);
            cmp("avg_turn_fx",     e.avg_turn, tdata[131:103]);
            cmp("dropped_flag",    e.dropped,  tuser);
            cmp("last_out",        e.is_last,  tlast);
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    sched_scoreboard sb;

    int gap_max    = 0;
    int burst_left = 0;
    int max_stall  = 0;
    int rdy_left   = 0;
    int jobs_sent  = 0;
    int jobs_lost  = 0;
    int set_fill   = 0;

    priority_schedule_wait_times DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    // receiver: ready runs of random length broken by stalls up to max_stall
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rdy_left <= 0;
        end else if (rdy_left != 0) begin
            rdy_left <= rdy_left - 1;
        end else if (m_tready && max_stall != 0) begin
            m_tready <= 1'b0;
            rdy_left <= $urandom_range(0, max_stall - 1);
        end else begin
            m_tready <= 1'b1;
            rdy_left <= $urandom_range(1, 12);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    task automatic send_job(input job_t j, input bit last);
        int gap;

        s_tdata  <= {j.prio, j.burst, j.id};
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_job(j, last);
        jobs_sent++;
        if (set_fill < CAP) set_fill++;
        else jobs_lost++;
        if (last) set_fill = 0;

        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            if (gap_max != 0) begin
                gap = $urandom_range(1, gap_max);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic send_fixed(input int id, input int burst, input int prio, input bit last);
        job_t j;

        j.id    = ID_W'(id);
        j.burst = BURST_W'(burst);
        j.prio  = PRIO_W'(prio);
        send_job(j, last);
    endtask

    // random set; a narrow priority span forces many ties
    task automatic send_set(input int count, input int prio_span);
        job_t j;
        int   pick;

        for (int k = 0; k < count; k++) begin
            j.id = ID_W'($urandom_range(0, 255));
            pick = $urandom_range(0, 9);
            if (pick == 0) j.burst = '0;
            else if (pick == 1) j.burst = 16'hffff;
            else j.burst = BURST_W'($urandom_range(0, 65535));
            pick = $urandom_range(0, 19);
            if (pick == 0) j.prio = '0;
            else if (pick == 1) j.prio = 8'hff;
            else j.prio = PRIO_W'($urandom_range(0, prio_span));
            send_job(j, k == count - 1);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        int size;
        int pick;
        int set_no;

        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single-job sets at both ends of every field
        send_fixed(0, 0, 0, 1'b1);
        send_fixed(255, 65535, 255, 1'b1);
        // ties and a descending order, checks the exchange order of equal priorities
        send_fixed(1, 100, 3, 1'b0);
        send_fixed(2, 65535, 1, 1'b0);
        send_fixed(3, 7, 3, 1'b0);
        send_fixed(4, 0, 1, 1'b0);
        send_fixed(5, 42, 0, 1'b1);
        // large bursts so the sums run wide
        send_fixed(170, 65535, 255, 1'b0);
        send_fixed(85, 65535, 128, 1'b0);
        send_fixed(15, 65535, 0, 1'b1);
        send_fixed(240, 1, 9, 1'b0);
        send_fixed(16, 2, 9, 1'b1);
        drain();

        // store exactly full, then a set whose extra jobs and last job are discarded
        max_stall = 6;
        gap_max   = 3;
        send_set(CAP, 255);
        send_set(CAP + 3, 255);
        drain();

        set_no = 0;
        while (jobs_sent - jobs_lost < 400) begin
            case ($urandom_range(0, 3))
                0: max_stall = 0;
                1: max_stall = 2;
                2: max_stall = 6;
                default: max_stall = 20;
            endcase
            case ($urandom_range(0, 2))
                0: gap_max = 0;
                1: gap_max = 3;
                default: gap_max = 10;
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 70) size = $urandom_range(1, 6);
            else if (pick < 85) size = $urandom_range(7, 16);
            else if (pick < 93) size = CAP;
            else size = $urandom_range(CAP + 1, CAP + 4);
            send_set(size, $urandom_range(0, 1) ? 3 : 255);
            set_no++;
            if (set_no % 10 == 0) drain();
        end

        drain();
        repeat (100) @(posedge aclk);

        $display("%0d jobs loaded (%0d discarded as over capacity) in %0d sets, %0d with overflow",
                 jobs_sent, jobs_lost, sb.sets_done, sb.overflow_sets);
        $display("%0d schedule results checked under varied sender gaps and receiver stalls",
                 sb.results_seen);
        if (sb.errors == 0) begin
            $display("** priority_schedule_wait_times: PASSED **");
        end else begin
            $display("** priority_schedule_wait_times: FAILED **");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("%0t: timeout, %0d results still expected", $time, sb.pending());
        $display("** priority_schedule_wait_times: FAILED **");
        $finish;
    end

endmodule
